### rtl/isim_pkg.sv
// Shared types, constants and helper functions for the interval set block.
// Used by isim_merge and interval_set_insert_merge_top; depends on nothing else.
package isim_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int VALUE_WIDTH = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int FIELD_W     = 16;
    localparam int POS_W       = 4;
    localparam int STAT_W      = 2;
    localparam int RAM_W       = 2 * VALUE_WIDTH;
    localparam int S_TDATA_W   = 2 * FIELD_W;
    localparam int M_FIELDS_W  = 2 * FIELD_W + POS_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W   = 1 + STAT_W;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [CNT_W-1:0]              count_t;
    typedef logic [ADDR_W-1:0]             addr_t;
    typedef logic [RAM_W-1:0]              entry_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    // Completion report of the merge pass.
    typedef struct packed {
        logic   valid;
        logic   drop;
        count_t count;
    } merge_done_t;

    // Input fields are read as VALUE_WIDTH-bit two's complement numbers.
    function automatic value_t ext_in(input logic [FIELD_W-1:0] raw);
        logic [63:0] wide;
        begin
            wide = {{(64 - FIELD_W){1'b0}}, raw};
            return wide[VALUE_WIDTH-1:0];
        end
    endfunction

    // Result fields carry the low VALUE_WIDTH bits, zero filled.
    function automatic logic [FIELD_W-1:0] pack_out(input value_t v);
        logic [63:0] wide;
        begin
            wide = {{(64 - VALUE_WIDTH){1'b0}}, v};
            return wide[FIELD_W-1:0];
        end
    endfunction

    function automatic logic [POS_W-1:0] pack_pos(input addr_t a);
        logic [63:0] wide;
        begin
            wide = {{(64 - ADDR_W){1'b0}}, a};
            return wide[POS_W-1:0];
        end
    endfunction

    function automatic value_t entry_start(input entry_t e);
        return value_t'(e[VALUE_WIDTH-1:0]);
    endfunction

    function automatic value_t entry_end(input entry_t e);
        return value_t'(e[RAM_W-1:VALUE_WIDTH]);
    endfunction

endpackage

### rtl/isim_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
module isim_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/isim_merge.sv
// Merge pass: walks the current table bank once and writes the updated table
// into the other bank. Depends on isim_pkg.
module isim_merge
    import isim_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  value_t      ns,
    input  value_t      ne,
    input  count_t      count,
    output logic        rd_en,
    output addr_t       rd_addr,
    input  entry_t      rd_data,
    output logic        wr_en,
    output addr_t       wr_addr,
    output entry_t      wr_data,
    output merge_done_t done
);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_SCAN = 3'b010,
        M_FIN  = 3'b100
    } mstate_t;

    // Where the scan stands relative to the new interval.
    typedef enum logic [2:0] {
        PH_BEFORE = 3'b001,
        PH_IN     = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        WS_CUR   = 2'd0,
        WS_NEW   = 2'd1,
        WS_MERGE = 2'd2,
        WS_CARRY = 2'd3
    } wsel_t;

    mstate_t state_reg, state_next;
    phase_t  phase_reg, phase_next;
    count_t  rd_idx_reg, rd_idx_next;
    count_t  wr_idx_reg, wr_idx_next;
    logic    rvld_reg, rvld_next;
    logic    drop_reg, drop_next;
    value_t  ms_reg, ms_next;
    value_t  me_reg, me_next;
    entry_t  carry_reg, carry_next;

    value_t  cur_s;
    value_t  cur_e;
    logic    full;
    logic    wr_req;
    wsel_t   wsel;

    assign cur_s   = entry_start(rd_data);
    assign cur_e   = entry_end(rd_data);
    assign full    = (count == count_t'(TABLE_DEPTH));
    assign rd_en   = (state_reg == M_SCAN) && (rd_idx_reg < count);
    assign rd_addr = rd_idx_reg[ADDR_W-1:0];
    assign wr_addr = wr_idx_reg[ADDR_W-1:0];
    assign wr_en   = wr_req && !drop_next;

    always_comb
    begin
        case (wsel)
            WS_CUR:   wr_data = rd_data;
            WS_NEW:   wr_data = {ne, ns};
            WS_MERGE: wr_data = {me_reg, ms_reg};
            WS_CARRY: wr_data = carry_reg;
            default:  wr_data = carry_reg;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        rvld_next   = 1'b0;
        drop_next   = drop_reg;
        ms_next     = ms_reg;
        me_next     = me_reg;
        carry_next  = carry_reg;
        wr_req      = 1'b0;
        wsel        = WS_CUR;
        done        = '0;

        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next  = M_SCAN;
                    phase_next  = PH_BEFORE;
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    drop_next   = 1'b0;
                end
            end

            M_SCAN:
            begin
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_reg + count_t'(1);
                    rvld_next   = 1'b1;
                end
                if (rvld_reg)
                begin
                    case (phase_reg)
                        PH_BEFORE:
                        begin
                            if (cur_e < ns)
                            begin
                                wr_req = 1'b1;
                                wsel   = WS_CUR;
                            end
                            else if (cur_s <= ne)
                            begin
                                ms_next    = (cur_s < ns) ? cur_s : ns;
                                me_next    = (cur_e > ne) ? cur_e : ne;
                                phase_next = PH_IN;
                            end
                            else
                            begin
                                // Insert before this entry; it moves up by one.
                                if (full)
                                begin
                                    drop_next = 1'b1;
                                end
                                wr_req     = 1'b1;
                                wsel       = WS_NEW;
                                carry_next = rd_data;
                                phase_next = PH_DONE;
                            end
                        end
                        PH_IN:
                        begin
                            if (cur_s <= ne)
                            begin
                                me_next = (cur_e > me_reg) ? cur_e : me_reg;
                            end
                            else
                            begin
                                wr_req     = 1'b1;
                                wsel       = WS_MERGE;
                                carry_next = rd_data;
                                phase_next = PH_DONE;
                            end
                        end
                        PH_DONE:
                        begin
                            wr_req     = 1'b1;
                            wsel       = WS_CARRY;
                            carry_next = rd_data;
                        end
                        default:
                        begin
                            phase_next = PH_DONE;
                        end
                    endcase
                end
                else if (rd_idx_reg == count)
                begin
                    state_next = M_FIN;
                end
            end

            M_FIN:
            begin
                wr_req = 1'b1;
                case (phase_reg)
                    PH_BEFORE:
                    begin
                        wsel = WS_NEW;
                        if (full)
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    PH_IN:   wsel = WS_MERGE;
                    PH_DONE: wsel = WS_CARRY;
                    default: wsel = WS_CARRY;
                endcase
                done.valid = 1'b1;
                done.drop  = drop_next;
                done.count = wr_idx_reg + count_t'(1);
                state_next = M_IDLE;
            end

            default:
            begin
                state_next = M_IDLE;
            end
        endcase

        if (wr_req)
        begin
            wr_idx_next = wr_idx_reg + count_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= M_IDLE;
            phase_reg  <= PH_BEFORE;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            rvld_reg   <= 1'b0;
            drop_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            rvld_reg   <= rvld_next;
            drop_reg   <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ms_reg    <= ms_next;
        me_reg    <= me_next;
        carry_reg <= carry_next;
    end

endmodule

### rtl/interval_set_insert_merge_top.sv
// Interval set with insert and merge. After an item is accepted, the first result is taken once
// the merge pass is through (a rejected item skips the pass), then one result per cycle while
// m_tready is high. The next item can be accepted in the cycle after the last result is taken.
// rst_n empties the table at once with no clearing pass. Depends on isim_pkg, isim_ram, isim_merge.
module interval_set_insert_merge_top
    import isim_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // new_start, new_end
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // entry_start, entry_end, entry_position, zero pad
    output logic                 m_tlast,   // last_entry
    output logic [M_TUSER_W-1:0] m_tuser    // table_empty, status
);

    typedef enum logic [3:0] {
        T_IDLE  = 4'b0001,
        T_MERGE = 4'b0010,
        T_PRIME = 4'b0100,
        T_OUT   = 4'b1000
    } tstate_t;

    tstate_t     state_reg, state_next;
    value_t      ns_reg, ns_next;
    value_t      ne_reg, ne_next;
    count_t      count_reg, count_next;
    logic        bank_reg, bank_next;
    status_t     status_reg, status_next;
    addr_t       pos_reg, pos_next;
    logic        out_valid_reg, out_valid_next;
    logic        empty_reg, empty_next;

    logic        in_hs;
    logic        out_hs;
    logic        last;
    logic        start;
    value_t      in_s;
    value_t      in_e;
    logic        out_re;
    addr_t       out_addr;

    logic        mg_rd_en;
    addr_t       mg_rd_addr;
    logic        mg_wr_en;
    addr_t       mg_wr_addr;
    entry_t      mg_wr_data;
    merge_done_t mg_done;

    logic [1:0]  ram_we;
    logic [1:0]  ram_re;
    addr_t       ram_raddr;
    entry_t      rdata0;
    entry_t      rdata1;
    entry_t      rdata;

    assign s_tready = (state_reg == T_IDLE);
    assign in_hs    = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign out_hs   = out_valid_reg && m_tready;
    assign in_s     = ext_in(s_tdata[FIELD_W-1:0]);
    assign in_e     = ext_in(s_tdata[2*FIELD_W-1:FIELD_W]);
    assign start    = in_hs && !(in_s > in_e);
    assign last     = empty_reg || ((count_t'(pos_reg) + count_t'(1)) == count_reg);

    // The merge pass reads the live bank and builds the new table in the other one.
    assign ram_raddr = (state_reg == T_MERGE) ? mg_rd_addr : out_addr;
    assign ram_re[0] = (mg_rd_en || out_re) && !bank_reg;
    assign ram_re[1] = (mg_rd_en || out_re) && bank_reg;
    assign ram_we[0] = mg_wr_en && bank_reg;
    assign ram_we[1] = mg_wr_en && !bank_reg;
    assign rdata     = bank_reg ? rdata1 : rdata0;

    isim_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_bank0 (
        .clk   (clk),
        .we    (ram_we[0]),
        .waddr (mg_wr_addr),
        .wdata (mg_wr_data),
        .re    (ram_re[0]),
        .raddr (ram_raddr),
        .rdata (rdata0)
    );

    isim_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_bank1 (
        .clk   (clk),
        .we    (ram_we[1]),
        .waddr (mg_wr_addr),
        .wdata (mg_wr_data),
        .re    (ram_re[1]),
        .raddr (ram_raddr),
        .rdata (rdata1)
    );

    isim_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .ns      (ns_reg),
        .ne      (ne_reg),
        .count   (count_reg),
        .rd_en   (mg_rd_en),
        .rd_addr (mg_rd_addr),
        .rd_data (rdata),
        .wr_en   (mg_wr_en),
        .wr_addr (mg_wr_addr),
        .wr_data (mg_wr_data),
        .done    (mg_done)
    );

    always_comb
    begin
        state_next     = state_reg;
        ns_next        = ns_reg;
        ne_next        = ne_reg;
        count_next     = count_reg;
        bank_next      = bank_reg;
        status_next    = status_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        empty_next     = empty_reg;
        out_re         = 1'b0;
        out_addr       = '0;

        case (state_reg)
            T_IDLE:
            begin
                if (in_hs)
                begin
                    ns_next = in_s;
                    ne_next = in_e;
                    if (in_s > in_e)
                    begin
                        status_next = ST_BAD;
                        state_next  = T_PRIME;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        state_next  = T_MERGE;
                    end
                end
            end

            T_MERGE:
            begin
                if (mg_done.valid)
                begin
                    if (mg_done.drop)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = mg_done.count;
                        bank_next  = !bank_reg;
                    end
                    state_next = T_PRIME;
                end
            end

            T_PRIME:
            begin
                pos_next       = '0;
                out_valid_next = 1'b1;
                empty_next     = (count_reg == '0);
                out_re         = (count_reg != '0);
                state_next     = T_OUT;
            end

            T_OUT:
            begin
                out_addr = pos_reg + addr_t'(1);
                if (out_hs)
                begin
                    if (last)
                    begin
                        out_valid_next = 1'b0;
                        state_next     = T_IDLE;
                    end
                    else
                    begin
                        // The RAM output register holds the shown entry until the next read.
                        out_re   = 1'b1;
                        pos_next = pos_reg + addr_t'(1);
                    end
                end
            end

            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            count_reg     <= '0;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            empty_reg     <= 1'b0;
            status_reg    <= ST_OK;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            bank_reg      <= bank_next;
            out_valid_reg <= out_valid_next;
            empty_reg     <= empty_next;
            status_reg    <= status_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ns_reg <= ns_next;
        ne_reg <= ne_next;
    end

    always_comb
    begin
        m_tdata = '0;
        if (!empty_reg)
        begin
            m_tdata[FIELD_W-1:0]             = pack_out(entry_start(rdata));
            m_tdata[2*FIELD_W-1:FIELD_W]     = pack_out(entry_end(rdata));
            m_tdata[M_FIELDS_W-1:2*FIELD_W]  = pack_pos(pos_reg);
        end
    end

    assign m_tlast = last;
    assign m_tuser = {status_reg, empty_reg};

    // No new item is taken while results of the previous one are pending.
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !m_tvalid)
        else $error("input accepted while results are pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && (count_reg == '0)))
        else $error("empty table report is not a single last result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block not idle after the last result of a run");

endmodule
